>>> rtl/bsbm_pkg.sv
// Shared types and constants for the break/sync bus master.
package bsbm_pkg;

	localparam logic [4:0]  MAX_FRAME     = 5'd16;
	localparam logic [7:0]  SYNC_BYTE     = 8'h55;
	localparam logic [15:0] BREAK_RESET   = 16'd677;
	localparam logic [15:0] TIMEOUT_RESET = 16'd1250;

	localparam int IN_DATA_W  = 24;
	localparam int IN_USER_W  = 3;
	localparam int OUT_DATA_W = 40;
	localparam int OUT_USER_W = 6;
	localparam int ADDR_W     = 3;

	localparam logic REG_BREAK   = 1'b0;
	localparam logic REG_TIMEOUT = 1'b1;

	typedef enum logic [2:0] {
		MODE_START   = 3'd0,
		MODE_LOAD    = 3'd1,
		MODE_TICK    = 3'd2,
		MODE_TX_RDY  = 3'd3,
		MODE_RX_BYTE = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		PH_REQUEST = 2'd0,
		PH_BREAK   = 2'd1,
		PH_SYNC    = 2'd2,
		PH_RX      = 2'd3
	} phase_t;

	typedef struct packed {
		logic [15:0] break_ticks;
		logic [15:0] timeout_ticks;
	} cfg_t;

	typedef struct packed {
		mode_t      mode;
		logic [7:0] data;
		logic [3:0] tx_slot;
		logic [4:0] send_count;
		logic [4:0] expect_count;
	} item_t;

	typedef struct packed {
		logic       line_low;
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       rx_valid;
		logic [7:0] rx_byte;
		logic [3:0] rx_position;
		logic       frame_done;
		logic [4:0] frame_length;
		logic       sync_error;
		logic       request_valid;
		logic [7:0] request_byte;
	} result_t;

endpackage

>>> rtl/bsbm_regs.sv
// APB configuration registers: break and timeout tick counts.
module bsbm_regs import bsbm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic [15:0] break_ticks_q;
	logic [15:0] timeout_ticks_q;
	logic        wr_en;
	logic        sel;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign sel    = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			break_ticks_q   <= BREAK_RESET;
			timeout_ticks_q <= TIMEOUT_RESET;
		end else if (wr_en) begin
			if (sel == REG_BREAK) begin
				break_ticks_q <= pwdata[15:0];
			end else begin
				timeout_ticks_q <= pwdata[15:0];
			end
		end
	end

	assign prdata = (sel == REG_BREAK) ? {16'd0, break_ticks_q} : {16'd0, timeout_ticks_q};
	assign cfg    = '{break_ticks: break_ticks_q, timeout_ticks: timeout_ticks_q};

endmodule

>>> rtl/bsbm_ctrl.sv
// Frame sequencer: phase, timer, counters, transmit buffer and result decode.
module bsbm_ctrl import bsbm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  item_t   item,
	input  cfg_t    cfg,
	output logic    hit,
	output result_t res
);

	phase_t      phase_q, phase_d;
	logic        timer_running_q, timer_running_d;
	logic [15:0] tick_count_q, tick_count_d;
	logic [4:0]  tx_len_q, tx_len_d;
	logic [4:0]  tx_idx_q, tx_idx_d;
	logic [4:0]  rx_len_q, rx_len_d;
	logic [4:0]  rx_idx_q, rx_idx_d;
	logic [7:0]  tx_buf_q [16];

	logic        is_start, is_load, is_tick, is_txrdy, is_rx;
	logic [15:0] tick_next, target;
	logic        tick_fire, tx_go, sync_bad, sync_empty, rx_take, rx_last, req;
	logic        end_frame;
	logic [4:0]  rx_idx_inc;

	assign is_start = fire && (item.mode == MODE_START);
	assign is_load  = fire && (item.mode == MODE_LOAD);
	assign is_tick  = fire && (item.mode == MODE_TICK);
	assign is_txrdy = fire && (item.mode == MODE_TX_RDY);
	assign is_rx    = fire && (item.mode == MODE_RX_BYTE);

	assign tick_next  = (tick_count_q != 16'hFFFF) ? tick_count_q + 16'd1 : tick_count_q;
	assign target     = (phase_q == PH_BREAK) ? cfg.break_ticks : cfg.timeout_ticks;
	assign tick_fire  = is_tick && timer_running_q && (tick_next >= target);
	assign tx_go      = is_txrdy && (phase_q != PH_BREAK) && (tx_idx_q < tx_len_q);
	assign sync_bad   = is_rx && (phase_q == PH_SYNC) && (item.data != SYNC_BYTE);
	assign sync_empty = is_rx && (phase_q == PH_SYNC) && (item.data == SYNC_BYTE)
		&& (rx_len_q == 5'd0);
	assign rx_take    = is_rx && (phase_q == PH_RX);
	assign rx_idx_inc = rx_idx_q + 5'd1;
	assign rx_last    = rx_take && (rx_idx_inc >= rx_len_q);
	assign req        = is_rx && (phase_q == PH_REQUEST);
	assign end_frame  = (tick_fire && (phase_q != PH_BREAK)) || sync_bad || sync_empty
		|| rx_last;

	// next state
	always_comb begin
		phase_d         = phase_q;
		timer_running_d = timer_running_q;
		tick_count_d    = tick_count_q;
		tx_len_d        = tx_len_q;
		tx_idx_d        = tx_idx_q;
		rx_len_d        = rx_len_q;
		rx_idx_d        = rx_idx_q;
		if (is_start) begin
			tx_len_d        = (item.send_count > MAX_FRAME) ? MAX_FRAME : item.send_count;
			rx_len_d        = (item.expect_count > MAX_FRAME) ? MAX_FRAME : item.expect_count;
			tx_idx_d        = 5'd0;
			rx_idx_d        = 5'd0;
			tick_count_d    = 16'd0;
			timer_running_d = 1'b1;
			phase_d         = PH_BREAK;
		end
		if (is_tick && timer_running_q) begin
			tick_count_d = tick_next;
			if (tick_fire && (phase_q == PH_BREAK)) begin
				tick_count_d = 16'd0;
				phase_d      = PH_SYNC;
			end
		end
		if (tx_go) begin
			tx_idx_d = tx_idx_q + 5'd1;
		end
		if (is_rx && (phase_q == PH_SYNC) && !sync_bad && !sync_empty) begin
			phase_d = PH_RX;
		end
		if (rx_take) begin
			rx_idx_d = rx_idx_inc;
			if (!rx_last) begin
				tick_count_d = 16'd0;
			end
		end
		if (end_frame) begin
			timer_running_d = 1'b0;
			phase_d         = PH_REQUEST;
		end
	end

	// result
	always_comb begin
		res           = '0;
		hit           = is_start || tick_fire || tx_go || sync_bad || sync_empty || rx_take
			|| req;
		res.line_low  = (phase_d == PH_BREAK);
		if (tick_fire && (phase_q == PH_BREAK)) begin
			res.tx_valid = 1'b1;
			res.tx_byte  = SYNC_BYTE;
		end
		if (tx_go) begin
			res.tx_valid = 1'b1;
			res.tx_byte  = tx_buf_q[tx_idx_q[3:0]];
		end
		if (rx_take) begin
			res.rx_valid    = 1'b1;
			res.rx_byte     = item.data;
			res.rx_position = rx_idx_q[3:0];
		end
		if (end_frame) begin
			res.frame_done = 1'b1;
			res.sync_error = sync_bad;
			if (rx_last) begin
				res.frame_length = rx_idx_inc;
			end else if (tick_fire && (phase_q == PH_RX)) begin
				res.frame_length = rx_idx_q;
			end
		end
		if (req) begin
			res.request_valid = 1'b1;
			res.request_byte  = item.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_REQUEST;
			timer_running_q <= 1'b0;
			tick_count_q    <= 16'd0;
			tx_len_q        <= 5'd0;
			tx_idx_q        <= 5'd0;
			rx_len_q        <= 5'd0;
			rx_idx_q        <= 5'd0;
		end else begin
			phase_q         <= phase_d;
			timer_running_q <= timer_running_d;
			tick_count_q    <= tick_count_d;
			tx_len_q        <= tx_len_d;
			tx_idx_q        <= tx_idx_d;
			rx_len_q        <= rx_len_d;
			rx_idx_q        <= rx_idx_d;
		end
	end

	always_ff @(posedge clk) begin
		if (is_load && ({1'b0, item.tx_slot} < MAX_FRAME)) begin
			tx_buf_q[item.tx_slot] <= item.data;
		end
	end

endmodule

>>> rtl/break_sync_bus_master.sv
// Top level of the break/sync bus master: stream channels, registers, sequencer.
//
//   channel   dir  group                                  transfer when
//   in        in   s_tvalid s_tready s_tdata s_tuser      s_tvalid & s_tready
//   out       out  m_tvalid m_tready m_tdata m_tuser      m_tvalid & m_tready
//   config    in   psel penable pwrite paddr pwdata ...   psel & penable & pwrite
//
// One input transfer per cycle while the output is not stalled; a result reaches m_tdata through both registers.
// Input register, then sequencer logic into the output register.
// Reset clears phase, timer and counters; the transmit buffer holds junk until loaded.
// m_tready low stalls the output register and, through it, s_tready.
module break_sync_bus_master import bsbm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// data[7:0], tx_slot[11:8], send_count[16:12], expect_count[21:17]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// mode[2:0]
	input  logic [IN_USER_W-1:0]  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// tx_byte[7:0], rx_byte[15:8], rx_position[19:16], frame_length[24:20],
	// request_byte[32:25]
	output logic [OUT_DATA_W-1:0] m_tdata,
	// line_low, tx_valid, rx_valid, frame_done, sync_error, request_valid
	output logic [OUT_USER_W-1:0] m_tuser,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_W-1:0]     paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res;
	result_t res_s2;
	logic    valid_s2;
	logic    hit;
	logic    advance;
	logic    fire;

	bsbm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign advance  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign fire     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.mode         <= mode_t'(s_tuser[2:0]);
			item_s1.data         <= s_tdata[7:0];
			item_s1.tx_slot      <= s_tdata[11:8];
			item_s1.send_count   <= s_tdata[16:12];
			item_s1.expect_count <= s_tdata[21:17];
		end
	end

	bsbm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg),
		.hit    (hit),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= fire && hit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && hit) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {7'd0, res_s2.request_byte, res_s2.frame_length, res_s2.rx_position,
		res_s2.rx_byte, res_s2.tx_byte};
	assign m_tuser  = {res_s2.request_valid, res_s2.sync_error, res_s2.frame_done,
		res_s2.rx_valid, res_s2.tx_valid, res_s2.line_low};

endmodule

>>> rtl/bsbm_checker.sv
// Port-level checks on the result channel, bound to the top level.
module bsbm_checker import bsbm_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic [OUT_USER_W-1:0] m_tuser
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $onehot0({m_tuser[5], m_tuser[2], m_tuser[1]}))
		else $error("more than one byte kind in a result");

	a_sync_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[4] |-> m_tuser[3] && (m_tdata[24:20] == 5'd0))
		else $error("sync error without empty frame end");

	a_break_alone: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> (m_tuser[5:1] == 5'd0) && (m_tdata == '0))
		else $error("break result carries other fields");

	a_last_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] && m_tuser[3]
			|-> m_tdata[24:20] == ({1'b0, m_tdata[19:16]} + 5'd1))
		else $error("frame length does not follow last position");

endmodule

bind break_sync_bus_master bsbm_checker u_bsbm_checker (.*);

>>> tb/tb_break_sync_bus_master.sv
// Self-checking testbench for the break/sync bus master: stream and register stimulus.
module tb_break_sync_bus_master;
	import bsbm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          CYCLE_LIMIT        = 1_000_000;
	localparam int          PHASE_ITEMS        = 120;
	localparam int          CALM_ITEMS         = 100;
	localparam logic [2:0]  MODE_UNKNOWN_FIRST = 3'd5;
	localparam logic [2:0]  MODE_UNKNOWN_LAST  = 3'd7;

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] data;
		logic [3:0] tx_slot;
		logic [4:0] send_count;
		logic [4:0] expect_count;
	} bus_item_t;

	typedef enum logic [2:0] {
		CHK_MODEL,
		CHK_NONE,
		CHK_REQUEST,
		CHK_BREAK,
		CHK_SYNC,
		CHK_DONE,
		CHK_SYNC_ERR
	} chk_t;

	typedef struct packed {
		bus_item_t  it;
		chk_t       chk;
		logic [7:0] val;
	} drill_row_t;

	// directed sequence, run with break_ticks 0 and timeout_ticks 2
	localparam drill_row_t DRILL [28] = '{
		'{'{MODE_RX_BYTE,      8'h00,     4'h0, 5'd0,  5'd0},  CHK_REQUEST,  8'h00},
		'{'{MODE_RX_BYTE,      8'hFF,     4'h0, 5'd0,  5'd0},  CHK_REQUEST,  8'hFF},
		'{'{MODE_TICK,         8'h00,     4'h0, 5'd0,  5'd0},  CHK_NONE,     8'h00},
		'{'{MODE_TX_RDY,       8'h00,     4'h0, 5'd0,  5'd0},  CHK_NONE,     8'h00},
		'{'{MODE_LOAD,         8'hA5,     4'h0, 5'd0,  5'd0},  CHK_NONE,     8'h00},
		'{'{MODE_LOAD,         8'hFF,     4'hF, 5'd0,  5'd0},  CHK_NONE,     8'h00},
		'{'{MODE_LOAD,         8'h00,     4'h1, 5'd0,  5'd0},  CHK_NONE,     8'h00},
		'{'{MODE_UNKNOWN_LAST, 8'hFF,     4'hF, 5'd31, 5'd31}, CHK_NONE,     8'h00},
		'{'{MODE_START,        8'hFF,     4'hF, 5'd31, 5'd31}, CHK_BREAK,    8'h00},
		'{'{MODE_TX_RDY,       8'h00,     4'h0, 5'd0,  5'd0},  CHK_NONE,     8'h00},
		'{'{MODE_RX_BYTE,      SYNC_BYTE, 4'h0, 5'd0,  5'd0},  CHK_NONE,     8'h00},
		'{'{MODE_TICK,         8'h00,     4'h0, 5'd0,  5'd0},  CHK_SYNC,     8'h00},
		'{'{MODE_TX_RDY,       8'h00,     4'h0, 5'd0,  5'd0},  CHK_MODEL,    8'h00},
		'{'{MODE_RX_BYTE,      SYNC_BYTE, 4'h0, 5'd0,  5'd0},  CHK_NONE,     8'h00},
		'{'{MODE_RX_BYTE,      8'h3C,     4'h0, 5'd0,  5'd0},  CHK_MODEL,    8'h00},
		'{'{MODE_TX_RDY,       8'h00,     4'h0, 5'd0,  5'd0},  CHK_MODEL,    8'h00},
		'{'{MODE_TICK,         8'h00,     4'h0, 5'd0,  5'd0},  CHK_NONE,     8'h00},
		'{'{MODE_TICK,         8'h00,     4'h0, 5'd0,  5'd0},  CHK_DONE,     8'h01},
		'{'{MODE_START,        8'h00,     4'h0, 5'd0,  5'd0},  CHK_BREAK,    8'h00},
		'{'{MODE_TICK,         8'h00,     4'h0, 5'd0,  5'd0},  CHK_SYNC,     8'h00},
		'{'{MODE_RX_BYTE,      SYNC_BYTE, 4'h0, 5'd0,  5'd0},  CHK_DONE,     8'h00},
		'{'{MODE_START,        8'h00,     4'h0, 5'd16, 5'd16}, CHK_BREAK,    8'h00},
		'{'{MODE_TICK,         8'h00,     4'h0, 5'd0,  5'd0},  CHK_SYNC,     8'h00},
		'{'{MODE_RX_BYTE,      8'hAA,     4'h0, 5'd0,  5'd0},  CHK_SYNC_ERR, 8'h00},
		'{'{MODE_START,        8'h00,     4'h0, 5'd1,  5'd1},  CHK_BREAK,    8'h00},
		'{'{MODE_TICK,         8'h00,     4'h0, 5'd0,  5'd0},  CHK_SYNC,     8'h00},
		'{'{MODE_TICK,         8'h00,     4'h0, 5'd0,  5'd0},  CHK_NONE,     8'h00},
		'{'{MODE_TICK,         8'h00,     4'h0, 5'd0,  5'd0},  CHK_DONE,     8'h00}
	};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [IN_USER_W-1:0]  s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b1;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [OUT_USER_W-1:0] m_tuser;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [ADDR_W-1:0]     paddr = '0;
	logic [31:0]           pwdata = '0;
	logic [31:0]           prdata;
	logic                  pready;

	// predicted block state
	phase_t      ph = PH_REQUEST;
	logic        timer_on = 1'b0;
	logic [15:0] tick_cnt = '0;
	logic [7:0]  tx_store [16];
	logic [15:0] store_written = '0;
	logic [4:0]  send_len = '0;
	logic [4:0]  send_idx = '0;
	logic [4:0]  recv_len = '0;
	logic [4:0]  recv_idx = '0;
	logic [15:0] brk_cfg = BREAK_RESET;
	logic [15:0] tmo_cfg = TIMEOUT_RESET;

	result_t pending_results [$];
	int      mismatches = 0;
	int      cycle_count = 0;
	bit      calm = 1'b0;
	int      tx_idle_pct = 15;
	int      rx_idle_pct = 15;
	int      tx_item_cnt = 0;

	break_sync_bus_master u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: run limit reached", $time);
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic void close_frame(inout result_t r, input logic [4:0] len, input logic err);
		r.frame_done   = 1'b1;
		r.frame_length = len;
		r.sync_error   = err;
		timer_on       = 1'b0;
		ph             = PH_REQUEST;
	endfunction

	function automatic bit frame_predict(input bus_item_t it, output result_t r);
		bit          fires;
		logic [15:0] target;
		r     = '0;
		fires = 1'b0;
		case (it.mode)
			MODE_START: begin
				send_len = (it.send_count > MAX_FRAME) ? MAX_FRAME : it.send_count;
				recv_len = (it.expect_count > MAX_FRAME) ? MAX_FRAME : it.expect_count;
				send_idx = '0;
				recv_idx = '0;
				tick_cnt = '0;
				timer_on = 1'b1;
				ph       = PH_BREAK;
				fires    = 1'b1;
			end
			MODE_LOAD: begin
				tx_store[it.tx_slot]      = it.data;
				store_written[it.tx_slot] = 1'b1;
			end
			MODE_TICK: begin
				if (timer_on) begin
					target = (ph == PH_BREAK) ? brk_cfg : tmo_cfg;
					if (tick_cnt != 16'hFFFF)
						tick_cnt++;
					if (tick_cnt >= target) begin
						fires = 1'b1;
						if (ph == PH_BREAK) begin
							r.tx_valid = 1'b1;
							r.tx_byte  = SYNC_BYTE;
							tick_cnt   = '0;
							ph         = PH_SYNC;
						end else begin
							close_frame(r, (ph == PH_RX) ? recv_idx : 5'd0, 1'b0);
						end
					end
				end
			end
			MODE_TX_RDY: begin
				if (ph != PH_BREAK && send_idx < send_len) begin
					r.tx_valid = 1'b1;
					r.tx_byte  = tx_store[send_idx[3:0]];
					send_idx++;
					fires = 1'b1;
				end
			end
			MODE_RX_BYTE: begin
				if (ph == PH_SYNC) begin
					if (it.data != SYNC_BYTE) begin
						close_frame(r, 5'd0, 1'b1);
						fires = 1'b1;
					end else if (recv_len == 0) begin
						close_frame(r, 5'd0, 1'b0);
						fires = 1'b1;
					end else begin
						ph = PH_RX;
					end
				end else if (ph == PH_RX) begin
					r.rx_valid    = 1'b1;
					r.rx_byte     = it.data;
					r.rx_position = recv_idx[3:0];
					recv_idx++;
					fires = 1'b1;
					if (recv_idx >= recv_len)
						close_frame(r, recv_idx, 1'b0);
					else
						tick_cnt = '0;
				end else if (ph == PH_REQUEST) begin
					r.request_valid = 1'b1;
					r.request_byte  = it.data;
					fires           = 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (fires)
			r.line_low = (ph == PH_BREAK);
		return fires;
	endfunction

	function automatic logic [4:0] pick_len();
		return ($urandom_range(0, 99) < 85) ? 5'($urandom_range(0, 6)) : 5'($urandom_range(0, 31));
	endfunction

	// mostly well-formed frames, steered by the predicted phase
	function automatic bus_item_t next_item();
		bus_item_t   it;
		int unsigned pick;
		it.data         = 8'($urandom);
		it.tx_slot      = 4'($urandom);
		it.send_count   = pick_len();
		it.expect_count = pick_len();
		pick            = $urandom_range(0, 99);
		case (ph)
			PH_REQUEST: begin
				if (pick < 25 || pick >= 92)
					it.mode = MODE_START;
				else if (pick < 45)
					it.mode = MODE_RX_BYTE;
				else if (pick < 65)
					it.mode = MODE_LOAD;
				else if (pick < 75)
					it.mode = MODE_TX_RDY;
				else if (pick < 85)
					it.mode = MODE_TICK;
				else
					it.mode = 3'($urandom_range(MODE_UNKNOWN_FIRST, MODE_UNKNOWN_LAST));
			end
			PH_BREAK: begin
				if (pick < 80)
					it.mode = MODE_TICK;
				else if (pick < 85)
					it.mode = MODE_TX_RDY;
				else if (pick < 90)
					it.mode = MODE_RX_BYTE;
				else if (pick < 95)
					it.mode = MODE_LOAD;
				else
					it.mode = MODE_START;
			end
			PH_SYNC: begin
				if (pick < 65) begin
					it.mode = MODE_RX_BYTE;
					it.data = SYNC_BYTE;
				end else if (pick < 75) begin
					it.mode = MODE_RX_BYTE;
				end else if (pick < 85) begin
					it.mode = MODE_TX_RDY;
				end else if (pick < 95) begin
					it.mode = MODE_TICK;
				end else begin
					it.mode = MODE_LOAD;
				end
			end
			default: begin
				if (pick < 55)
					it.mode = MODE_RX_BYTE;
				else if (pick < 70)
					it.mode = MODE_TX_RDY;
				else if (pick < 85)
					it.mode = MODE_TICK;
				else if (pick < 92)
					it.mode = MODE_LOAD;
				else if (pick < 95)
					it.mode = MODE_START;
				else
					it.mode = 3'($urandom_range(MODE_UNKNOWN_FIRST, MODE_UNKNOWN_LAST));
			end
		endcase
		// never read a buffer slot that was not loaded: load it instead
		if (it.mode == MODE_TX_RDY && ph != PH_BREAK && send_idx < send_len &&
				!store_written[send_idx[3:0]]) begin
			it.mode    = MODE_LOAD;
			it.tx_slot = send_idx[3:0];
		end
		return it;
	endfunction

	task automatic transfer(input bus_item_t it, input chk_t chk, input logic [7:0] val);
		result_t r;
		result_t typed;
		bit      fires;
		tx_item_cnt++;
		if (tx_item_cnt % 32 == 0)
			tx_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 5 + 20 * $urandom_range(0, 1);
		if (!calm && $urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, it.expect_count, it.send_count, it.tx_slot, it.data};
		s_tuser  <= it.mode;
		do @(posedge clk); while (!s_tready);
		fires = frame_predict(it, r);
		typed = '0;
		case (chk)
			CHK_MODEL: begin
				if (fires)
					pending_results.push_back(r);
			end
			CHK_NONE: begin
			end
			CHK_REQUEST: begin
				typed.request_valid = 1'b1;
				typed.request_byte  = val;
				pending_results.push_back(typed);
			end
			CHK_BREAK: begin
				typed.line_low = 1'b1;
				pending_results.push_back(typed);
			end
			CHK_SYNC: begin
				typed.tx_valid = 1'b1;
				typed.tx_byte  = SYNC_BYTE;
				pending_results.push_back(typed);
			end
			CHK_DONE: begin
				typed.frame_done   = 1'b1;
				typed.frame_length = val[4:0];
				pending_results.push_back(typed);
			end
			default: begin
				typed.frame_done = 1'b1;
				typed.sync_error = 1'b1;
				pending_results.push_back(typed);
			end
		endcase
	endtask

	// drop valid, let all results drain and the pipeline empty
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic check_reg(input logic reg_sel, input logic [15:0] want);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {reg_sel, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[15:0] !== want) begin
			mismatches++;
			$display("%0t: register %0d expected %h actual %h", $time, reg_sel, want, prdata[15:0]);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_reg(input logic reg_sel, input logic [15:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_sel, 2'b00};
		pwdata  <= {16'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (reg_sel == REG_BREAK)
			brk_cfg = value;
		else
			tmo_cfg = value;
		check_reg(reg_sel, value);
	endtask

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s expected %h actual %h", $time, name, want, got);
		end
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (cycle_count % 32 == 0)
				rx_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 5 + 20 * $urandom_range(0, 1);
			if (!calm && $urandom_range(0, 99) < rx_idle_pct) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got               = '0;
			got.tx_byte       = m_tdata[7:0];
			got.rx_byte       = m_tdata[15:8];
			got.rx_position   = m_tdata[19:16];
			got.frame_length  = m_tdata[24:20];
			got.request_byte  = m_tdata[32:25];
			got.line_low      = m_tuser[0];
			got.tx_valid      = m_tuser[1];
			got.rx_valid      = m_tuser[2];
			got.frame_done    = m_tuser[3];
			got.sync_error    = m_tuser[4];
			got.request_valid = m_tuser[5];
			if (pending_results.size() == 0) begin
				mismatches++;
				$display("%0t: expected no transfer, actual tdata %h tuser %b",
					$time, m_tdata, m_tuser);
			end else begin
				want = pending_results.pop_front();
				check_field("line_low", 8'(want.line_low), 8'(got.line_low));
				check_field("tx_valid", 8'(want.tx_valid), 8'(got.tx_valid));
				check_field("tx_byte", want.tx_byte, got.tx_byte);
				check_field("rx_valid", 8'(want.rx_valid), 8'(got.rx_valid));
				check_field("rx_byte", want.rx_byte, got.rx_byte);
				check_field("rx_position", 8'(want.rx_position), 8'(got.rx_position));
				check_field("frame_done", 8'(want.frame_done), 8'(got.frame_done));
				check_field("frame_length", 8'(want.frame_length), 8'(got.frame_length));
				check_field("sync_error", 8'(want.sync_error), 8'(got.sync_error));
				check_field("request_valid", 8'(want.request_valid), 8'(got.request_valid));
				check_field("request_byte", want.request_byte, got.request_byte);
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_reg(REG_BREAK, BREAK_RESET);
		check_reg(REG_TIMEOUT, TIMEOUT_RESET);

		// break of zero behaves as one tick
		set_reg(REG_BREAK, 16'd0);
		set_reg(REG_TIMEOUT, 16'd2);
		for (int i = 0; i < $size(DRILL); i++)
			transfer(DRILL[i].it, DRILL[i].chk, DRILL[i].val);

		for (int p = 0; p < 4; p++) begin
			settle();
			case (p)
				0: begin
					set_reg(REG_BREAK, 16'd1);
					set_reg(REG_TIMEOUT, 16'd1);
				end
				1: begin
					set_reg(REG_BREAK, 16'($urandom_range(2, 6)));
					set_reg(REG_TIMEOUT, 16'($urandom_range(3, 12)));
				end
				2: begin
					set_reg(REG_BREAK, 16'($urandom_range(1, 4)));
					set_reg(REG_TIMEOUT, 16'hFFFF);
				end
				default: begin
					set_reg(REG_BREAK, 16'($urandom_range(1, 3)));
					set_reg(REG_TIMEOUT, 16'($urandom_range(2, 8)));
				end
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++)
				transfer(next_item(), CHK_MODEL, 8'h00);
		end

		// back to back with no idling on either side
		calm = 1'b1;
		settle();
		set_reg(REG_BREAK, 16'($urandom_range(1, 3)));
		set_reg(REG_TIMEOUT, 16'($urandom_range(2, 8)));
		for (int i = 0; i < CALM_ITEMS; i++)
			transfer(next_item(), CHK_MODEL, 8'h00);

		settle();
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/bsbm_pkg.sv
rtl/bsbm_regs.sv
rtl/bsbm_ctrl.sv
rtl/break_sync_bus_master.sv
rtl/bsbm_checker.sv
tb/tb_break_sync_bus_master.sv
